// File: sv/bspll_pkg.sv
// bspll_pkg: shared constants, codes and control types of the bsp point leaf lookup
// used by bspll_ctrl, bspll_dp and bsp_point_leaf_lookup_core
package bspll_pkg;

  // table sizes, powers of two: indexes wrap by dropping high bits
  localparam int NODE_COUNT  = 4096;
  localparam int PLANE_COUNT = 4096;
  localparam int LEAF_COUNT  = 4096;
  localparam int MAX_STEPS   = 64;

  localparam int NODE_AW  = $clog2(NODE_COUNT);
  localparam int PLANE_AW = $clog2(PLANE_COUNT);
  localparam int LEAF_AW  = $clog2(LEAF_COUNT);
  localparam int STEP_W   = $clog2(MAX_STEPS + 1);

  // field widths
  localparam int IDX_W    = 12;
  localparam int CHILD_W  = 13;
  localparam int NRM_W    = 16;
  localparam int COORD_W  = 32;
  localparam int PROD_W   = NRM_W + COORD_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int OFF_SH   = 14;
  localparam int LEAF_W   = 12;
  localparam int STEPS_W  = 7;
  localparam int STEPS_SAT = 127;

  localparam int IN_DATA_W  = 232;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    ACT_WR_NODE  = 2'd0,
    ACT_WR_PLANE = 2'd1,
    ACT_QUERY    = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_WRITE_DONE = 2'd0,
    ST_LEAF       = 2'd1,
    ST_LIMIT      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    LANE_X = 2'd0,
    LANE_Y = 2'd1,
    LANE_Z = 2'd2
  } lane_t;

  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_NODE_RD  = 3'd1,
    S_PLANE_RD = 3'd2,
    S_MUL      = 3'd3,
    S_LAST     = 3'd4,
    S_DONE     = 3'd5
  } state_t;

  typedef struct packed {
    logic [PLANE_AW-1:0]       plane;
    logic signed [CHILD_W-1:0] front;
    logic signed [CHILD_W-1:0] back;
  } node_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
  } normal_t;

  // controller to datapath
  typedef struct packed {
    logic  accept;
    logic  wr_node;
    logic  wr_plane;
    logic  start;
    logic  mul;
    lane_t lane;
    logic  step;
    logic  load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_leaf;
    logic at_limit;
    logic out_free;
  } sts_t;

endpackage

// File: sv/bspll_ctrl.sv
// bspll_ctrl: state machine that sequences writes and the node walk of a query
// depends on bspll_pkg; drives bspll_dp through cmd_t and reads sts_t
module bspll_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  bspll_pkg::action_t in_action,
  output logic              in_tready,
  output bspll_pkg::cmd_t   cmd,
  input  bspll_pkg::sts_t   sts
);

  bspll_pkg::state_t state_r, state_nxt;
  bspll_pkg::lane_t  lane_r, lane_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bspll_pkg::S_IDLE;
      lane_r  <= bspll_pkg::LANE_X;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lane_nxt  = lane_r;
    cmd       = '0;
    in_tready = (state_r == bspll_pkg::S_IDLE);
    case (state_r)
      bspll_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          case (in_action)
            bspll_pkg::ACT_WR_NODE:  cmd.wr_node  = 1'b1;
            bspll_pkg::ACT_WR_PLANE: cmd.wr_plane = 1'b1;
            bspll_pkg::ACT_QUERY:    cmd.start    = 1'b1;
            default: ;
          endcase
          state_nxt = (in_action == bspll_pkg::ACT_QUERY) ? bspll_pkg::S_NODE_RD
                                                          : bspll_pkg::S_DONE;
        end
      end
      bspll_pkg::S_NODE_RD: begin
        state_nxt = bspll_pkg::S_PLANE_RD;
      end
      bspll_pkg::S_PLANE_RD: begin
        state_nxt = bspll_pkg::S_MUL;
        lane_nxt  = bspll_pkg::LANE_X;
      end
      bspll_pkg::S_MUL: begin
        cmd.mul  = 1'b1;
        cmd.lane = lane_r;
        case (lane_r)
          bspll_pkg::LANE_X: lane_nxt = bspll_pkg::LANE_Y;
          bspll_pkg::LANE_Y: lane_nxt = bspll_pkg::LANE_Z;
          default: begin
            lane_nxt  = bspll_pkg::LANE_X;
            state_nxt = bspll_pkg::S_LAST;
          end
        endcase
      end
      bspll_pkg::S_LAST: begin
        cmd.step = 1'b1;
        if (sts.is_leaf || sts.at_limit) begin
          state_nxt = bspll_pkg::S_DONE;
        end else begin
          state_nxt = bspll_pkg::S_NODE_RD;
        end
      end
      bspll_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = bspll_pkg::S_IDLE;
        end
      end
      default: state_nxt = bspll_pkg::S_IDLE;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r != bspll_pkg::S_IDLE)
    else $error("accepted word did not start work");

  a_done_waits_for_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bspll_pkg::S_DONE && !sts.out_free) |=> state_r == bspll_pkg::S_DONE)
    else $error("result dropped while output register full");

  a_walk_ends_on_leaf_or_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bspll_pkg::S_LAST && (sts.is_leaf || sts.at_limit))
      |=> state_r == bspll_pkg::S_DONE)
    else $error("walk continued past leaf or step limit");

endmodule

// File: sv/bspll_dp.sv
// bspll_dp: node and plane memories, shared multiplier, accumulator, walk and output registers
// depends on bspll_pkg; controlled by bspll_ctrl through cmd_t, reports sts_t
module bspll_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  bspll_pkg::cmd_t                          cmd,
  output bspll_pkg::sts_t                          sts,
  input  logic [bspll_pkg::IDX_W-1:0]              entry_index,
  input  logic [bspll_pkg::IDX_W-1:0]              split_plane,
  input  logic signed [bspll_pkg::CHILD_W-1:0]     front_child,
  input  logic signed [bspll_pkg::CHILD_W-1:0]     back_child,
  input  logic signed [bspll_pkg::NRM_W-1:0]       normal_x,
  input  logic signed [bspll_pkg::NRM_W-1:0]       normal_y,
  input  logic signed [bspll_pkg::NRM_W-1:0]       normal_z,
  input  logic signed [bspll_pkg::COORD_W-1:0]     plane_offset,
  input  logic signed [bspll_pkg::COORD_W-1:0]     point_x,
  input  logic signed [bspll_pkg::COORD_W-1:0]     point_y,
  input  logic signed [bspll_pkg::COORD_W-1:0]     point_z,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [bspll_pkg::LEAF_W-1:0]             out_leaf,
  output bspll_pkg::status_t                       out_status,
  output logic [bspll_pkg::STEPS_W-1:0]            out_steps
);

  localparam int AW = bspll_pkg::ACC_W;
  localparam int PW = bspll_pkg::PROD_W;

  // memories, contents undefined until written
  bspll_pkg::node_t                       node_mem   [bspll_pkg::NODE_COUNT];
  bspll_pkg::normal_t                     normal_mem [bspll_pkg::PLANE_COUNT];
  logic signed [bspll_pkg::COORD_W-1:0]   offset_mem [bspll_pkg::PLANE_COUNT];

  bspll_pkg::node_t                       node_q;
  bspll_pkg::normal_t                     normal_q;
  logic signed [bspll_pkg::COORD_W-1:0]   offset_q;

  logic [bspll_pkg::NODE_AW-1:0]          cur_r;
  logic [bspll_pkg::PLANE_AW-1:0]         plane_addr;
  logic signed [bspll_pkg::COORD_W-1:0]   px_r, py_r, pz_r;
  logic signed [PW-1:0]                   prod_r;
  logic signed [AW-1:0]                   acc_r;
  logic [bspll_pkg::STEP_W-1:0]           steps_r;
  logic [bspll_pkg::LEAF_W-1:0]           leaf_r;
  bspll_pkg::status_t                     status_r;

  logic                                   out_valid_r;
  logic [bspll_pkg::LEAF_W-1:0]           out_leaf_r;
  bspll_pkg::status_t                     out_status_r;
  logic [bspll_pkg::STEPS_W-1:0]          out_steps_r;

  logic                                   node_wr_ok, plane_wr_ok;
  logic [bspll_pkg::NODE_AW-1:0]          node_waddr;
  logic [bspll_pkg::PLANE_AW-1:0]         plane_waddr;
  logic signed [bspll_pkg::NRM_W-1:0]     mul_a;
  logic signed [bspll_pkg::COORD_W-1:0]   mul_b;
  logic signed [AW-1:0]                   prod_ext, off_ext, side_dist;
  logic signed [bspll_pkg::CHILD_W-1:0]   child_sel;
  logic [bspll_pkg::LEAF_W-1:0]           leaf_code;
  logic [bspll_pkg::STEPS_W-1:0]          steps_sat;

  assign node_wr_ok  = (32'(entry_index) < bspll_pkg::NODE_COUNT);
  assign plane_wr_ok = (32'(entry_index) < bspll_pkg::PLANE_COUNT);
  assign node_waddr  = bspll_pkg::NODE_AW'(entry_index);
  assign plane_waddr = bspll_pkg::PLANE_AW'(entry_index);

  always_ff @(posedge clk) begin
    if (cmd.wr_node && node_wr_ok) begin
      node_mem[node_waddr] <= '{plane: bspll_pkg::PLANE_AW'(split_plane),
                                front: front_child, back: back_child};
    end
    node_q <= node_mem[cur_r];
  end

  assign plane_addr = node_q.plane;

  always_ff @(posedge clk) begin
    if (cmd.wr_plane && plane_wr_ok) begin
      normal_mem[plane_waddr] <= '{nx: normal_x, ny: normal_y, nz: normal_z};
      offset_mem[plane_waddr] <= plane_offset;
    end
    normal_q <= normal_mem[plane_addr];
    offset_q <= offset_mem[plane_addr];
  end

  // one shared multiplier, one axis per cycle
  always_comb begin
    case (cmd.lane)
      bspll_pkg::LANE_X: begin mul_a = normal_q.nx; mul_b = px_r; end
      bspll_pkg::LANE_Y: begin mul_a = normal_q.ny; mul_b = py_r; end
      default:           begin mul_a = normal_q.nz; mul_b = pz_r; end
    endcase
  end

  assign prod_ext  = {{(AW-PW){prod_r[PW-1]}}, prod_r};
  assign off_ext   = {{(AW-bspll_pkg::COORD_W-bspll_pkg::OFF_SH){offset_q[bspll_pkg::COORD_W-1]}},
                      offset_q, {bspll_pkg::OFF_SH{1'b0}}};
  assign side_dist = acc_r + prod_ext;

  // front on zero or more; a negative child c names leaf -(c+1) = ~c
  assign child_sel = side_dist[AW-1] ? node_q.back : node_q.front;
  assign leaf_code = bspll_pkg::LEAF_W'(bspll_pkg::LEAF_AW'(~child_sel[bspll_pkg::LEAF_W-1:0]));

  assign sts.is_leaf  = child_sel[bspll_pkg::CHILD_W-1];
  assign sts.at_limit = (steps_r == bspll_pkg::STEP_W'(bspll_pkg::MAX_STEPS - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px_r  <= point_x;
      py_r  <= point_y;
      pz_r  <= point_z;
      cur_r <= '0;
    end
    if (cmd.mul) begin
      prod_r <= mul_a * mul_b;
      if (cmd.lane == bspll_pkg::LANE_X) begin
        acc_r <= '0 - off_ext;
      end else begin
        acc_r <= side_dist;
      end
    end
    if (cmd.accept) begin
      leaf_r   <= '0;
      status_r <= bspll_pkg::ST_WRITE_DONE;
      steps_r  <= '0;
    end else if (cmd.step) begin
      steps_r <= steps_r + 1'b1;
      if (sts.is_leaf) begin
        leaf_r   <= leaf_code;
        status_r <= bspll_pkg::ST_LEAF;
      end else if (sts.at_limit) begin
        leaf_r   <= '0;
        status_r <= bspll_pkg::ST_LIMIT;
      end else begin
        cur_r <= bspll_pkg::NODE_AW'(child_sel[bspll_pkg::CHILD_W-2:0]);
      end
    end
  end

  assign steps_sat = (32'(steps_r) > bspll_pkg::STEPS_SAT) ?
                     bspll_pkg::STEPS_W'(bspll_pkg::STEPS_SAT) : bspll_pkg::STEPS_W'(steps_r);

  // output register parts the walk from the result side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_leaf_r   <= leaf_r;
      out_status_r <= status_r;
      out_steps_r  <= steps_sat;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_leaf   = out_leaf_r;
  assign out_status = out_status_r;
  assign out_steps  = out_steps_r;

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("output word not presented after load");

  a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> 32'(steps_r) < bspll_pkg::MAX_STEPS)
    else $error("walk stepped past the step limit");

  a_limit_has_no_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && status_r == bspll_pkg::ST_LIMIT)
      |-> (leaf_r == '0 && 32'(steps_r) == bspll_pkg::MAX_STEPS))
    else $error("step limit result carries a leaf or wrong step count");

endmodule

// File: sv/bsp_point_leaf_lookup_core.sv
// bsp_point_leaf_lookup_core: top level of the bsp tree point lookup
// depends on bspll_pkg, bspll_ctrl and bspll_dp
//
//  channel | dir | tvalid/tready          | tuser        | tdata
//  in_     | in  | word accepted on both  | action       | write entries and query point
//  out_    | out | word taken on both     | status       | leaf_found, steps_taken
//
// a write word goes from accept to the done state, where its result is loaded into
// the output register once that register has room; the controller then goes idle
// a query walks each node visited through node read, plane read, three multiplies
// through one shared 16x32 multiplier, then the final add and branch
// a new word is accepted while the previous result waits in the output register
// reset (rst_n low, synchronous) clears the controller and the output valid only;
// the node and plane memories hold nothing defined until written
module bsp_point_leaf_lookup_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // entry_index[11:0] split_plane[23:12] front_child[36:24] back_child[49:37]
  // normal_x[65:50] normal_y[81:66] normal_z[97:82] plane_offset[129:98]
  // point_x[161:130] point_y[193:162] point_z[225:194] zero fill[231:226]
  input  logic [bspll_pkg::IN_DATA_W-1:0]       in_tdata,
  // action[1:0]
  input  logic [1:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // leaf_found[11:0] steps_taken[18:12] zero fill[23:19]
  output logic [bspll_pkg::OUT_DATA_W-1:0]      out_tdata,
  // status[1:0]
  output logic [1:0]                            out_tuser
);

  bspll_pkg::cmd_t                   cmd;
  bspll_pkg::sts_t                   sts;
  logic [bspll_pkg::LEAF_W-1:0]      out_leaf;
  bspll_pkg::status_t                out_status;
  logic [bspll_pkg::STEPS_W-1:0]     out_steps;

  bspll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (bspll_pkg::action_t'(in_tuser)),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bspll_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .entry_index  (in_tdata[11:0]),
    .split_plane  (in_tdata[23:12]),
    .front_child  (in_tdata[36:24]),
    .back_child   (in_tdata[49:37]),
    .normal_x     (in_tdata[65:50]),
    .normal_y     (in_tdata[81:66]),
    .normal_z     (in_tdata[97:82]),
    .plane_offset (in_tdata[129:98]),
    .point_x      (in_tdata[161:130]),
    .point_y      (in_tdata[193:162]),
    .point_z      (in_tdata[225:194]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_leaf     (out_leaf),
    .out_status   (out_status),
    .out_steps    (out_steps)
  );

  assign out_tdata = {5'b0, out_steps, out_leaf};
  assign out_tuser = out_status;

endmodule

// File: test/bsp_point_leaf_lookup_core_tb.sv
// bsp_point_leaf_lookup_core_tb: self-checking bench for the bsp tree point lookup
// depends on bspll_pkg and bsp_point_leaf_lookup_core; builds trees, walks them in a
// local predictor and compares every output word with the expected leaf, status and steps
module bsp_point_leaf_lookup_core_tb;
  import bspll_pkg::*;

  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam int MODE_MIXED = 0;
  localparam int MODE_DEEP  = 1;
  localparam int MODE_LOOP  = 2;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int DRAIN_CYCLES = 2 + 6 * MAX_STEPS + 16;

  typedef struct {
    logic [1:0]                act;
    logic [IDX_W-1:0]          entry_index;
    logic [IDX_W-1:0]          split_plane;
    logic signed [CHILD_W-1:0] front_child;
    logic signed [CHILD_W-1:0] back_child;
    logic signed [NRM_W-1:0]   nx, ny, nz;
    logic signed [COORD_W-1:0] offset;
    logic signed [COORD_W-1:0] px, py, pz;
  } bsp_word_t;

  typedef struct packed {
    logic [LEAF_W-1:0]  leaf;
    status_t            status;
    logic [STEPS_W-1:0] steps;
  } lookup_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  // local copy of the tree tables and which entries have been written
  node_t                     tree_nodes   [NODE_COUNT];
  normal_t                   tree_normals [PLANE_COUNT];
  logic signed [COORD_W-1:0] tree_offsets [PLANE_COUNT];
  bit                        node_written  [NODE_COUNT];
  bit                        plane_written [PLANE_COUNT];

  lookup_result_t pending_results[$];

  int  error_count = 0;
  int  items_sent = 0;
  int  writes_sent = 0;
  int  queries_sent = 0;
  int  unknown_sent = 0;
  int  leaf_hits = 0;
  int  limit_hits = 0;
  int  cycle_count = 0;
  int  hold_cycles = 0;
  bit  no_idle = 1'b0;

  bsp_point_leaf_lookup_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // walks the local tree from node 0; flags a walk that touches an unwritten entry
  function automatic lookup_result_t walk_tree(input logic signed [COORD_W-1:0] px, py, pz,
                                               output bit unsafe);
    lookup_result_t r;
    logic [NODE_AW-1:0] cur;
    node_t nd;
    normal_t nm;
    longint d;
    int c;
    r.leaf = '0;
    r.status = ST_LIMIT;
    r.steps = '0;
    cur = '0;
    unsafe = 1'b0;
    for (int n = 1; n <= MAX_STEPS; n++) begin
      nd = tree_nodes[cur];
      if (!node_written[cur] || !plane_written[nd.plane]) begin
        unsafe = 1'b1;
        return r;
      end
      nm = tree_normals[nd.plane];
      d = longint'(nm.nx) * longint'(px) + longint'(nm.ny) * longint'(py)
        + longint'(nm.nz) * longint'(pz) - longint'(tree_offsets[nd.plane]) * 64'sd16384;
      c = (d >= 0) ? nd.front : nd.back;
      r.steps = STEPS_W'(n);
      if (c < 0) begin
        r.leaf = LEAF_W'(-(c + 1));
        r.status = ST_LEAF;
        return r;
      end
      cur = c[NODE_AW-1:0];
    end
    return r;
  endfunction

  // updates the local tables and gives the word the block should answer with
  function automatic lookup_result_t apply_word(input bsp_word_t it);
    lookup_result_t r;
    bit unsafe;
    r = '{leaf: '0, status: ST_WRITE_DONE, steps: '0};
    case (it.act)
      ACT_WR_NODE: begin
        tree_nodes[it.entry_index] = '{plane: it.split_plane, front: it.front_child,
                                       back: it.back_child};
        node_written[it.entry_index] = 1'b1;
        writes_sent++;
      end
      ACT_WR_PLANE: begin
        tree_normals[it.entry_index] = '{nx: it.nx, ny: it.ny, nz: it.nz};
        tree_offsets[it.entry_index] = it.offset;
        plane_written[it.entry_index] = 1'b1;
        writes_sent++;
      end
      ACT_QUERY: begin
        r = walk_tree(it.px, it.py, it.pz, unsafe);
        queries_sent++;
      end
      default: unknown_sent++;
    endcase
    return r;
  endfunction

  function automatic bsp_word_t random_word();
    bsp_word_t it;
    it.act = 2'($urandom_range(0, 3));
    it.entry_index = IDX_W'($urandom);
    it.split_plane = IDX_W'($urandom);
    it.front_child = CHILD_W'($urandom);
    it.back_child = CHILD_W'($urandom);
    it.nx = NRM_W'($urandom);
    it.ny = NRM_W'($urandom);
    it.nz = NRM_W'($urandom);
    it.offset = $urandom;
    it.px = $urandom;
    it.py = $urandom;
    it.pz = $urandom;
    return it;
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return COORD_W'(int'($urandom_range(0, 131072)) - 65536);
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return COORD_W'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
    endcase
  endfunction

  function automatic logic signed [NRM_W-1:0] random_normal();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      default: return NRM_W'($urandom);
    endcase
  endfunction

  // one word on the input channel; queries that would read unwritten entries are dropped
  task automatic send_word(input bsp_word_t it);
    int gap;
    bit unsafe;
    lookup_result_t r;
    if (it.act == ACT_QUERY) begin
      r = walk_tree(it.px, it.py, it.pz, unsafe);
      if (unsafe) return;
    end
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.act;
    in_tdata <= {6'b0, it.pz, it.py, it.px, it.offset, it.nz, it.ny, it.nx,
                 it.back_child, it.front_child, it.split_plane, it.entry_index};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_word(it));
    items_sent++;
  endtask

  task automatic wr_node(input int idx, input int plane, input int front, input int back);
    bsp_word_t it;
    it = random_word();
    it.act = ACT_WR_NODE;
    it.entry_index = idx[IDX_W-1:0];
    it.split_plane = plane[IDX_W-1:0];
    it.front_child = front[CHILD_W-1:0];
    it.back_child = back[CHILD_W-1:0];
    send_word(it);
  endtask

  task automatic wr_plane(input int idx, input logic signed [NRM_W-1:0] nx, ny, nz,
                          input logic signed [COORD_W-1:0] offset);
    bsp_word_t it;
    it = random_word();
    it.act = ACT_WR_PLANE;
    it.entry_index = idx[IDX_W-1:0];
    it.nx = nx;
    it.ny = ny;
    it.nz = nz;
    it.offset = offset;
    send_word(it);
  endtask

  task automatic query(input logic signed [COORD_W-1:0] px, py, pz);
    bsp_word_t it;
    it = random_word();
    it.act = ACT_QUERY;
    it.px = px;
    it.py = py;
    it.pz = pz;
    send_word(it);
  endtask

  // writes a few planes and a tree rooted at node 0, then queries it
  task automatic run_tree_round(input int mode);
    int k;
    int nq;
    int c;
    int kids[2];
    int ids[$];
    int planes[$];
    bit taken[int];
    bsp_word_t it;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_word(random_word());
    end
    repeat ($urandom_range(1, 6)) begin
      c = $urandom_range(0, PLANE_COUNT - 1);
      planes.push_back(c);
      wr_plane(c, random_normal(), random_normal(), random_normal(), random_coord());
    end
    k = (mode == MODE_DEEP) ? $urandom_range(16, 45) : $urandom_range(2, 20);
    ids.push_back(0);
    taken[0] = 1'b1;
    while (ids.size() < k) begin
      c = $urandom_range(1, NODE_COUNT - 1);
      if (!taken.exists(c)) begin
        taken[c] = 1'b1;
        ids.push_back(c);
      end
    end
    for (int i = k - 1; i >= 0; i--) begin
      for (int s = 0; s < 2; s++) begin
        case (mode)
          MODE_DEEP: begin
            if (i + 2 < k) kids[s] = ids[i + 1 + $urandom_range(0, 1)];
            else if (i + 1 < k && $urandom_range(0, 1) != 0) kids[s] = ids[i + 1];
            else kids[s] = -int'($urandom_range(1, LEAF_COUNT));
          end
          MODE_LOOP: begin
            // children may point back up, so most walks never reach a leaf
            if ($urandom_range(0, 15) == 0) kids[s] = -int'($urandom_range(1, LEAF_COUNT));
            else kids[s] = ids[$urandom_range(0, k - 1)];
          end
          default: begin
            if (i + 1 < k && $urandom_range(0, 2) != 0) kids[s] = ids[$urandom_range(i + 1, k - 1)];
            else kids[s] = -int'($urandom_range(1, LEAF_COUNT));
          end
        endcase
      end
      wr_node(ids[i], planes[$urandom_range(0, planes.size() - 1)], kids[0], kids[1]);
      // a query in the middle of the build
      if ($urandom_range(0, 11) == 0) query(random_coord(), random_coord(), random_coord());
    end
    nq = $urandom_range(3, 12);
    repeat (nq) begin
      if ($urandom_range(0, 9) == 0) begin
        it = random_word();
        send_word(it);
      end else begin
        query(random_coord(), random_coord(), random_coord());
      end
    end
  endtask

  task automatic random_rounds(input int target);
    int r;
    while (items_sent < target) begin
      r = $urandom_range(0, 9);
      run_tree_round((r < 6) ? MODE_MIXED : (r < 9) ? MODE_DEEP : MODE_LOOP);
    end
  endtask

  task automatic test_directed();
    bsp_word_t it;
    // x plane through the origin: zero distance goes front
    wr_plane(0, 16'sd16384, 16'sd0, 16'sd0, 32'sd0);
    wr_node(0, 0, -1, -LEAF_COUNT);
    query(32'sd1, 32'sd0, 32'sd0);
    query(32'sd0, $urandom, $urandom);
    query(-32'sd1, 32'sd0, 32'sd0);
    // extreme normals, offsets and child codes
    wr_plane(PLANE_COUNT - 1, 16'sh8000, 16'sh7fff, 16'sh8000, 32'sh8000_0000);
    wr_plane(1, 16'sh7fff, 16'sh8000, 16'sh7fff, 32'sh7fff_ffff);
    wr_node(0, 0, NODE_COUNT - 1, 1);
    wr_node(NODE_COUNT - 1, PLANE_COUNT - 1, -2048, -LEAF_COUNT);
    wr_node(1, 1, -1, NODE_COUNT - 1);
    query(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    query(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    query(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    query(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    query(-32'sd1, 32'sd0, 32'sd0);
    it = random_word();
    it.act = ACT_UNKNOWN;
    send_word(it);
    // cycles in the tree run into the step limit, then a two-node walk ends at a leaf
    wr_node(2, 0, 2, 2);
    wr_node(0, 0, 2, 2);
    query(random_coord(), random_coord(), random_coord());
    wr_node(0, PLANE_COUNT - 1, 0, 0);
    query(random_coord(), random_coord(), random_coord());
    wr_node(PLANE_COUNT - 2, PLANE_COUNT - 1, -LEAF_COUNT, NODE_COUNT - 1);
    wr_node(0, 0, NODE_COUNT - 2, -1);
    query(32'sd256, 32'sd0, 32'sd0);
  endtask

  task automatic test_random_trees();
    random_rounds(1650);
  endtask

  // the receiver stops for a long stretch while words keep being offered at the input
  task automatic test_backpressure();
    hold_cycles = 500;
    run_tree_round(MODE_MIXED);
    run_tree_round(MODE_DEEP);
  endtask

  task automatic test_steady();
    no_idle = 1'b1;
    random_rounds(1900);
  endtask

  initial begin
    int gap;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 17);
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("output word with nothing pending: tdata %h tuser %0d", out_tdata, out_tuser);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tuser == ST_LEAF) leaf_hits++;
        if (out_tuser == ST_LIMIT) limit_hits++;
        if (out_tdata[LEAF_W-1:0] !== exp_r.leaf) begin
          $error("leaf_found: expected %0d, got %0d", exp_r.leaf, out_tdata[LEAF_W-1:0]);
          error_count++;
        end
        if (out_tuser !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_tuser);
          error_count++;
        end
        if (out_tdata[LEAF_W +: STEPS_W] !== exp_r.steps) begin
          $error("steps_taken: expected %0d, got %0d", exp_r.steps,
                 out_tdata[LEAF_W +: STEPS_W]);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_trees();
    test_backpressure();
    test_steady();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d words: %0d table writes, %0d lookups, %0d unknown actions",
             items_sent, writes_sent, queries_sent, unknown_sent);
    $display("lookups ended at a leaf %0d times and at the step limit %0d times",
             leaf_hits, limit_hits);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
